@@ sv/gbs_pkg.sv @@
// Shared types and constants of the greedy box suppression block.
`timescale 1ns / 1ps

package gbs_pkg;

    // Fixed field widths.
    localparam int POS_W      = 16;
    localparam int THR_W      = 8;
    localparam int MAXB_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [POS_W-1:0]  POS_MAX    = 16'hFFFF;
    localparam logic [THR_W-1:0]  THR_RESET  = 8'd128;
    localparam logic [MAXB_W-1:0] MAXB_RESET = 9'd200;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BOXES     = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the incoming box
        logic calc_area;  // form the box area, restart the scan
        logic rd_en;      // read the next kept box
        logic decide;     // post the result, update the kept list
    } gbs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // every kept box has been read, or the box cannot be kept
        logic pipe_busy;  // comparisons still in flight
        logic out_free;   // result register can take a new result
    } gbs_sts_t;

endpackage

@@ sv/greedy_box_suppression_core.sv @@
// Top level of the greedy box suppression core: controller, datapath and checks.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Contents
// s_*       input      s_valid / s_ready  one box: corners and end-of-set flag
// m_*       output     m_valid / m_ready  one result: keep flag, position, end-of-set
// cfg_*     input      cfg_we             register index and write data
//
// m_valid rises after the accepting edge once the box has passed through the
// area, scan, drain and decision states; the scan reads nothing when no kept
// box needs comparing. The scan reads one kept box per cycle from the single read
// port of the kept-box memory, and the read plus four compare stages drain
// before the decision. s_ready returns as the result appears, so only one box
// is in progress at a time.
// Reset is synchronous and active low; the kept list needs no clearing pass.
// A result waiting on m_ready does not block the next input transaction, but
// the following result is held until the output register is free.

module greedy_box_suppression_core #(
    parameter int MAX_KEPT   = 256,
    parameter int COORD_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [COORD_BITS-1:0]          s_x_min,
    input  logic [COORD_BITS-1:0]          s_y_min,
    input  logic [COORD_BITS-1:0]          s_x_max,
    input  logic [COORD_BITS-1:0]          s_y_max,
    input  logic                           s_last_in_set,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_keep,
    output logic [gbs_pkg::POS_W-1:0]      m_box_position,
    output logic                           m_set_done,

    input  logic                           cfg_we,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import gbs_pkg::*;

    gbs_cmd_t cmd;
    gbs_sts_t sts;

    // The controller walks each box through capture, area, scan, drain and
    // decision, and only opens the input while no box is in progress.
    gbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the configuration, the kept-box memory, the overlap
    // pipeline that tests intersection*256 against threshold*union, and the
    // result register that separates the output from the scan.
    gbs_datapath #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_x_min        (s_x_min),
        .s_y_min        (s_y_min),
        .s_x_max        (s_x_max),
        .s_y_max        (s_y_max),
        .s_last_in_set  (s_last_in_set),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_keep         (m_keep),
        .m_box_position (m_box_position),
        .m_set_done     (m_set_done)
    );

    // A kept box always lies within the store's capacity.
    a_keep_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_keep |-> m_box_position < POS_W'(MAX_KEPT))
        else $error("kept box beyond store capacity");

    // The decision must wait until every comparison has left the pipeline.
    a_decide_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |-> !sts.pipe_busy)
        else $error("decision taken with comparisons in flight");

    // No read past the end of the kept list.
    a_read_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> !sts.scan_done)
        else $error("kept-box read after end of scan");

    // Once a transaction is taken, the input closes until that box is decided.
    a_one_box: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_ready)
        else $error("input reopened while a box is in progress");

endmodule

@@ sv/gbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gbs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/gbs_datapath.sv @@
// Datapath: box registers, kept-box memory, overlap pipeline, counters and result register.
`timescale 1ns / 1ps

module gbs_datapath #(
    parameter int MAX_KEPT   = 256,
    parameter int COORD_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gbs_pkg::gbs_cmd_t             cmd,
    output gbs_pkg::gbs_sts_t             sts,
    input  logic [COORD_BITS-1:0]         s_x_min,
    input  logic [COORD_BITS-1:0]         s_y_min,
    input  logic [COORD_BITS-1:0]         s_x_max,
    input  logic [COORD_BITS-1:0]         s_y_max,
    input  logic                          s_last_in_set,
    input  logic                          cfg_we,
    input  logic [gbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_keep,
    output logic [gbs_pkg::POS_W-1:0]     m_box_position,
    output logic                          m_set_done
);

    import gbs_pkg::*;

    localparam int SPAN_W = COORD_BITS + 1;
    localparam int AREA_W = 2 * SPAN_W;
    localparam int UNI_W  = AREA_W + 1;
    localparam int PROD_W = UNI_W + THR_W;
    localparam int BOX_W  = 4 * COORD_BITS;
    localparam int ADDR_W = $clog2(MAX_KEPT);
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);

    // Inclusive pixel span from lo to hi, zero when hi is below lo.
    function automatic logic [SPAN_W-1:0] span_f(input logic [COORD_BITS-1:0] lo,
                                                 input logic [COORD_BITS-1:0] hi);
        logic [SPAN_W-1:0] d;
        d = {1'b0, hi} - {1'b0, lo};
        return (hi >= lo) ? d + SPAN_W'(1) : '0;
    endfunction

    function automatic logic [COORD_BITS-1:0] max_f(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [COORD_BITS-1:0] min_f(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // Configuration and control state.
    logic [THR_W-1:0]  thr_reg;
    logic [MAXB_W-1:0] maxb_reg;
    logic [CNT_W-1:0]  kept_cnt_reg, kept_cnt_next;
    logic [POS_W-1:0]  seen_reg, seen_next;
    logic [CNT_W-1:0]  scan_addr_reg;
    logic              rd_vld_reg, s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic              hit_reg;
    logic              m_valid_reg;

    // Current box.
    logic [BOX_W-1:0]  box_reg;
    logic              last_reg;
    logic              elig_reg;
    logic [SPAN_W-1:0] spx_reg, spy_reg;
    logic [AREA_W-1:0] area_b_reg;

    // Overlap pipeline.
    logic [SPAN_W-1:0] iw_reg, ih_reg, kw_reg, kh_reg;
    logic [AREA_W-1:0] inter2_reg, area_k_reg;
    logic [AREA_W-1:0] inter3_reg;
    logic [UNI_W-1:0]  uni_reg;
    logic [AREA_W-1:0] inter4_reg;
    logic [PROD_W-1:0] prod_reg;

    // Result payload.
    logic              keep_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              done_reg;

    logic [BOX_W-1:0]      rdata;
    logic [COORD_BITS-1:0] bx0, by0, bx1, by1;
    logic [COORD_BITS-1:0] kx0, ky0, kx1, ky1;
    logic                  elig_c;
    logic                  keep_c;
    logic                  hit_c;

    assign bx0 = box_reg[BOX_W-1 -: COORD_BITS];
    assign by0 = box_reg[BOX_W-1-COORD_BITS -: COORD_BITS];
    assign bx1 = box_reg[2*COORD_BITS-1 -: COORD_BITS];
    assign by1 = box_reg[COORD_BITS-1:0];
    assign kx0 = rdata[BOX_W-1 -: COORD_BITS];
    assign ky0 = rdata[BOX_W-1-COORD_BITS -: COORD_BITS];
    assign kx1 = rdata[2*COORD_BITS-1 -: COORD_BITS];
    assign ky1 = rdata[COORD_BITS-1:0];

    // A box may be kept only inside the box limit and while the store has room.
    assign elig_c = (seen_reg < POS_W'(maxb_reg)) && (seen_reg < POS_W'(MAX_KEPT)) &&
                    (kept_cnt_reg < CNT_W'(MAX_KEPT));
    assign keep_c = elig_reg && !hit_reg;
    assign hit_c  = {1'b0, inter4_reg, THR_W'(0)} > prod_reg;

    always_comb begin
        kept_cnt_next = kept_cnt_reg;
        seen_next     = seen_reg;
        if (last_reg) begin
            kept_cnt_next = '0;
            seen_next     = '0;
        end else begin
            if (keep_c) begin
                kept_cnt_next = kept_cnt_reg + CNT_W'(1);
            end
            if (seen_reg != POS_MAX) begin
                seen_next = seen_reg + POS_W'(1);
            end
        end
    end

    gbs_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_KEPT)
    ) u_kept_ram (
        .aclk  (aclk),
        .we    (cmd.decide && keep_c),
        .waddr (kept_cnt_reg[ADDR_W-1:0]),
        .wdata (box_reg),
        .re    (cmd.rd_en),
        .raddr (scan_addr_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= THR_RESET;
            maxb_reg      <= MAXB_RESET;
            kept_cnt_reg  <= '0;
            seen_reg      <= '0;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_IOU_THRESHOLD: thr_reg  <= cfg_wdata[THR_W-1:0];
                    REG_MAX_BOXES:     maxb_reg <= cfg_wdata[MAXB_W-1:0];
                    default:           ;
                endcase
            end

            if (cmd.calc_area) begin
                scan_addr_reg <= '0;
            end else if (cmd.rd_en) begin
                scan_addr_reg <= scan_addr_reg + CNT_W'(1);
            end

            rd_vld_reg <= cmd.rd_en;
            s1_vld_reg <= rd_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;

            if (cmd.calc_area) begin
                hit_reg <= 1'b0;
            end else if (s4_vld_reg && hit_c) begin
                hit_reg <= 1'b1;
            end

            if (cmd.decide) begin
                kept_cnt_reg <= kept_cnt_next;
                seen_reg     <= seen_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            box_reg  <= {s_x_min, s_y_min, s_x_max, s_y_max};
            last_reg <= s_last_in_set;
            elig_reg <= elig_c;
            spx_reg  <= span_f(s_x_min, s_x_max);
            spy_reg  <= span_f(s_y_min, s_y_max);
        end
        if (cmd.calc_area) begin
            area_b_reg <= AREA_W'(spx_reg) * AREA_W'(spy_reg);
        end

        // Stage 1: overlap extents and kept-box sides.
        iw_reg <= span_f(max_f(bx0, kx0), min_f(bx1, kx1));
        ih_reg <= span_f(max_f(by0, ky0), min_f(by1, ky1));
        kw_reg <= span_f(kx0, kx1);
        kh_reg <= span_f(ky0, ky1);
        // Stage 2: intersection and kept-box area.
        inter2_reg <= AREA_W'(iw_reg) * AREA_W'(ih_reg);
        area_k_reg <= AREA_W'(kw_reg) * AREA_W'(kh_reg);
        // Stage 3: union.
        uni_reg    <= {1'b0, area_b_reg} + {1'b0, area_k_reg} - {1'b0, inter2_reg};
        inter3_reg <= inter2_reg;
        // Stage 4: threshold times union.
        prod_reg   <= PROD_W'(thr_reg) * PROD_W'(uni_reg);
        inter4_reg <= inter3_reg;

        if (cmd.decide) begin
            keep_reg <= keep_c;
            pos_reg  <= seen_reg;
            done_reg <= last_reg;
        end
    end

    assign sts.scan_done = !elig_reg || (scan_addr_reg == kept_cnt_reg);
    assign sts.pipe_busy = rd_vld_reg || s1_vld_reg || s2_vld_reg || s3_vld_reg || s4_vld_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_keep         = keep_reg;
    assign m_box_position = pos_reg;
    assign m_set_done     = done_reg;

endmodule

@@ sv/gbs_ctrl.sv @@
// Controller state machine: sequences capture, scan, drain and decision for each box.
`timescale 1ns / 1ps

module gbs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gbs_pkg::gbs_sts_t sts,
    output gbs_pkg::gbs_cmd_t cmd
);

    import gbs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_AREA;
                end
            end
            ST_AREA: begin
                cmd.calc_area = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.rd_en = !sts.scan_done;
                if (sts.scan_done) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ test/greedy_box_suppression_core_tb.sv @@
// Self-checking testbench for the greedy box suppression core.
`timescale 1ns / 1ps

// The testbench feeds boxes from a queue through a valid/ready driver and
// checks every result transaction against a behavioral model of greedy
// suppression that runs at the moment each box is accepted. The run starts
// with a short directed sequence covering the overlap boundary, inverted
// corners, empty unions, the box limit and a register change in the middle
// of a set. Random sets of clustered boxes follow under three idling
// profiles and several register settings.

module greedy_box_suppression_core_tb;

    import gbs_pkg::*;

    localparam int MAX_KEPT    = 256;
    localparam int COORD_BITS  = 12;
    localparam int COORD_TOP   = (1 << COORD_BITS) - 1;
    // Every result has been seen before the pause starts, so the idle pause
    // only has to let the block settle.
    localparam int SETTLE      = 16;
    localparam int SUB_ITEMS   = 165;
    localparam int CYCLE_LIMIT = 10_000_000;

    typedef struct packed {
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
    } box_t;

    typedef struct packed {
        box_t b;
        logic last;
    } stim_t;

    typedef struct packed {
        logic             keep;
        logic [POS_W-1:0] pos;
        logic             done;
    } verdict_t;

    // Every input starts at a known value.
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [COORD_BITS-1:0] s_x_min       = '0;
    logic [COORD_BITS-1:0] s_y_min       = '0;
    logic [COORD_BITS-1:0] s_x_max       = '0;
    logic [COORD_BITS-1:0] s_y_max       = '0;
    logic                  s_last_in_set = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_keep;
    logic [POS_W-1:0]      m_box_position;
    logic                  m_set_done;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    // Boxes waiting to be driven and results waiting to be observed.
    stim_t    box_q[$];
    verdict_t verdict_q[$];

    // Shadow of the block's suppression state and registers.
    box_t        kept_store[MAX_KEPT];
    int unsigned kept_total = 0;
    int unsigned set_pos    = 0;
    logic [7:0]  thr_cfg    = THR_RESET;
    int unsigned limit_cfg  = MAXB_RESET;

    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     err_cnt       = 0;
    longint cycle_cnt     = 0;

    stim_t    nxt_box;
    box_t     got_box;
    verdict_t head;

    greedy_box_suppression_core #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_x_min        (s_x_min),
        .s_y_min        (s_y_min),
        .s_x_max        (s_x_max),
        .s_y_max        (s_y_max),
        .s_last_in_set  (s_last_in_set),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_keep         (m_keep),
        .m_box_position (m_box_position),
        .m_set_done     (m_set_done),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Pixels covered from lo to hi inclusive; an inverted side covers none.
    function automatic longint unsigned pix_span(int unsigned lo, int unsigned hi);
        return (hi >= lo) ? longint'(hi - lo) + 1 : 0;
    endfunction

    function automatic longint unsigned box_area(box_t b);
        return pix_span(b.x0, b.x1) * pix_span(b.y0, b.y1);
    endfunction

    // IoU above thr/256, compared exactly as inter*256 > thr*union. With an
    // empty union both sides are zero, so the box is never suppressed.
    function automatic bit over_thr(box_t a, box_t b, logic [7:0] thr);
        longint unsigned iw, ih, inter, uni;
        iw = pix_span((a.x0 > b.x0) ? a.x0 : b.x0, (a.x1 < b.x1) ? a.x1 : b.x1);
        ih = pix_span((a.y0 > b.y0) ? a.y0 : b.y0, (a.y1 < b.y1) ? a.y1 : b.y1);
        inter = iw * ih;
        uni = box_area(a) + box_area(b) - inter;
        return (inter * 256) > (longint'(thr) * uni);
    endfunction

    // Decides one accepted box and queues the result it must produce.
    function automatic void judge_box(box_t b, logic last);
        int unsigned limit;
        int unsigned i;
        verdict_t    v;
        limit  = (limit_cfg < MAX_KEPT) ? limit_cfg : MAX_KEPT;
        v.keep = 1'b0;
        if (set_pos < limit && kept_total < MAX_KEPT) begin
            v.keep = 1'b1;
            for (i = 0; i < kept_total; i++) begin
                if (over_thr(b, kept_store[i], thr_cfg)) begin
                    v.keep = 1'b0;
                    break;
                end
            end
            if (v.keep) begin
                kept_store[kept_total] = b;
                kept_total++;
            end
        end
        v.pos  = set_pos[POS_W-1:0];
        v.done = last;
        verdict_q = {verdict_q, v};
        // The position saturates, which puts every later box past the limit.
        if (set_pos < POS_MAX) begin
            set_pos++;
        end
        if (last) begin
            kept_total = 0;
            set_pos    = 0;
        end
    endfunction

    // Driver. The payload registers still hold the accepted box at the edge
    // of acceptance, so the model sees exactly what the block took. A new
    // box is only presented once the previous one is gone, and each output
    // gets one nonblocking assignment per edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                got_box = '{s_x_min, s_y_min, s_x_max, s_y_max};
                judge_box(got_box, s_last_in_set);
            end
            if (!s_valid || s_ready) begin
                if (box_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt_box = box_q.pop_front();
                    s_valid       <= 1'b1;
                    s_x_min       <= nxt_box.b.x0;
                    s_y_min       <= nxt_box.b.y0;
                    s_x_max       <= nxt_box.b.x1;
                    s_y_max       <= nxt_box.b.y1;
                    s_last_in_set <= nxt_box.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Stalls the result channel at random and checks each result
    // transaction against the oldest expectation.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("result transaction with no box outstanding: position %0d",
                       m_box_position);
                err_cnt++;
            end else begin
                head = verdict_q.pop_front();
                if (m_keep !== head.keep) begin
                    $error("keep mismatch: expected %0d, actual %0d", head.keep, m_keep);
                    err_cnt++;
                end
                if (m_box_position !== head.pos) begin
                    $error("box_position mismatch: expected %0d, actual %0d",
                           head.pos, m_box_position);
                    err_cnt++;
                end
                if (m_set_done !== head.done) begin
                    $error("set_done mismatch: expected %0d, actual %0d",
                           head.done, m_set_done);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int clip(int v);
        return (v < 0) ? 0 : ((v > COORD_TOP) ? COORD_TOP : v);
    endfunction

    function automatic int jitter(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    task automatic push_box(int x0, int y0, int x1, int y1, bit last);
        stim_t s;
        s.b.x0 = x0[COORD_BITS-1:0];
        s.b.y0 = y0[COORD_BITS-1:0];
        s.b.x1 = x1[COORD_BITS-1:0];
        s.b.y1 = y1[COORD_BITS-1:0];
        s.last = last;
        box_q = {box_q, s};
    endtask

    // One set of n boxes. Most boxes are scattered around a few anchors so
    // that overlaps land on both sides of the threshold; the rest are free
    // boxes, boxes with arbitrary (often inverted) corners and boxes on the
    // frame border.
    task automatic add_set(int n);
        int ax[4], ay[4], aw[4], ah[4];
        int na, k, i, sel, w, h, x0, y0, x1, y1;
        na = $urandom_range(1, 4);
        for (k = 0; k < na; k++) begin
            aw[k] = $urandom_range(1, 700);
            ah[k] = $urandom_range(1, 700);
            ax[k] = $urandom_range(0, 4096 - aw[k]);
            ay[k] = $urandom_range(0, 4096 - ah[k]);
        end
        for (i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            k   = $urandom_range(0, na - 1);
            if (sel < 70) begin
                w  = aw[k] + jitter(aw[k] / 4);
                h  = ah[k] + jitter(ah[k] / 4);
                x0 = clip(ax[k] + jitter(aw[k] / 4));
                y0 = clip(ay[k] + jitter(ah[k] / 4));
                x1 = clip(x0 + ((w < 1) ? 1 : w) - 1);
                y1 = clip(y0 + ((h < 1) ? 1 : h) - 1);
            end else if (sel < 85) begin
                x0 = $urandom_range(0, COORD_TOP);
                y0 = $urandom_range(0, COORD_TOP);
                x1 = clip(x0 + int'($urandom_range(0, 1500)));
                y1 = clip(y0 + int'($urandom_range(0, 1500)));
            end else if (sel < 93) begin
                x0 = $urandom_range(0, COORD_TOP);
                y0 = $urandom_range(0, COORD_TOP);
                x1 = $urandom_range(0, COORD_TOP);
                y1 = $urandom_range(0, COORD_TOP);
            end else begin
                x0 = $urandom_range(1) ? 0 : $urandom_range(0, COORD_TOP);
                y0 = $urandom_range(1) ? 0 : $urandom_range(0, COORD_TOP);
                x1 = $urandom_range(1) ? COORD_TOP : clip(x0 + int'($urandom_range(0, 50)));
                y1 = $urandom_range(1) ? COORD_TOP : clip(y0 + int'($urandom_range(0, 50)));
            end
            push_box(x0, y0, x1, y1, i == n - 1);
        end
    endtask

    // Register write; the model follows at the edge the block takes it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_IOU_THRESHOLD) begin
            thr_cfg = val[THR_W-1:0];
        end else begin
            limit_cfg = val[MAXB_W-1:0];
        end
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] mb);
        write_reg(REG_IOU_THRESHOLD, thr);
        write_reg(REG_MAX_BOXES, mb);
    endtask

    // Every queued box accepted and every result seen, then a short pause.
    task automatic wait_idle();
        while (box_q.size() != 0 || s_valid || verdict_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_phase(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] mb);
        int cnt, n;
        configure(thr, mb);
        cnt = 0;
        while (cnt < SUB_ITEMS) begin
            n = ($urandom_range(99) < 90) ? $urandom_range(1, 24) : $urandom_range(25, 80);
            add_set(n);
            cnt += n;
        end
        wait_idle();
    endtask

    initial begin
        int i;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 59;

        // Reset settings: threshold one half, limit 200.
        // The full frame is kept, then an identical copy is suppressed.
        push_box(0, 0, COORD_TOP, COORD_TOP, 1'b0);
        push_box(0, 0, COORD_TOP, COORD_TOP, 1'b0);
        // The top half has an IoU of exactly one half and survives; one more
        // row tips it over the threshold.
        push_box(0, 0, COORD_TOP, 2047, 1'b0);
        push_box(0, 0, COORD_TOP, 2048, 1'b0);
        // Inverted corners give zero area; the second one meets the first
        // with an empty union and is kept as well.
        push_box(100, 100, 50, 200, 1'b0);
        push_box(300, 300, 300, 10, 1'b0);
        push_box(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, 1'b1);
        // A set left open while the threshold drops to zero: from then on a
        // single shared pixel suppresses.
        push_box(10, 10, 19, 19, 1'b0);
        wait_idle();
        write_reg(REG_IOU_THRESHOLD, 9'h000);
        push_box(19, 19, 40, 40, 1'b0);
        push_box(20, 20, 40, 40, 1'b1);
        wait_idle();
        // Data bit 8 falls outside the threshold register, leaving 255.
        // Only an identical box exceeds it, and the limit of two stops the
        // rest of the set.
        configure(9'h1FF, 9'd2);
        push_box(500, 500, 899, 899, 1'b0);
        push_box(500, 500, 899, 899, 1'b0);
        push_box(1000, 1000, 1099, 1099, 1'b0);
        push_box(2000, 0, 2000, 0, 1'b1);
        wait_idle();
        // A limit of zero keeps nothing.
        write_reg(REG_MAX_BOXES, 9'd0);
        push_box(0, 0, COORD_TOP, COORD_TOP, 1'b0);
        push_box(0, 0, 0, 0, 1'b1);
        wait_idle();
        write_reg(REG_MAX_BOXES, 9'd1);
        push_box(0, 0, 0, 0, 1'b0);
        push_box(COORD_TOP, 0, COORD_TOP, 0, 1'b1);
        wait_idle();

        random_phase(9'h080, 9'd200);
        // A limit above the store: a grid of 260 disjoint boxes fills every
        // entry, and the boxes past the store size are dropped.
        configure(9'h1FF, 9'd511);
        for (i = 0; i < 260; i++) begin
            push_box((i % 32) * 128, (i / 32) * 128,
                     (i % 32) * 128 + 99, (i / 32) * 128 + 99, i == 259);
        end
        wait_idle();
        random_phase(9'h1FF, 9'd511);

        send_idle_pct = 59;
        recv_idle_pct = 32;
        random_phase(9'h000, 9'd256);
        random_phase(9'h001, 9'd5);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(9'($urandom_range(0, 511)), 9'($urandom_range(1, 300)));
        random_phase(9'd230, 9'd1);

        // A short closing set with a limit of three.
        write_reg(REG_MAX_BOXES, 9'd3);
        add_set(6);
        wait_idle();

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/gbs_pkg.sv
sv/gbs_ram.sv
sv/gbs_datapath.sv
sv/gbs_ctrl.sv
sv/greedy_box_suppression_core.sv
test/greedy_box_suppression_core_tb.sv
